@@ sv/fixed_block_free_list_allocator_unit_assert.svh @@
// Assertion macros for the fixed block free list allocator.
// Included by the top level; depends on nothing else.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define FBFL_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define FBFL_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

@@ sv/fbfl_pkg.sv @@
// Shared constants, types and helpers of the fixed block free list allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package fbfl_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = 11;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // a transaction is taken this cycle
      logic follow_link;  // load the head from the link read last cycle
   } fbfl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic link_needed;  // the offered item is an allocate that must follow a link
   } fbfl_sts_type;

   // Effective pool size: the register clamped to 1 .. MAX_BLOCKS.
   function automatic logic [CNT_W-1:0] pool_size(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] n;
      n = count;
      if (n == '0) begin
         n = CNT_W'(1);
      end
      if (n > CNT_W'(MAX_BLOCKS)) begin
         n = CNT_W'(MAX_BLOCKS);
      end
      return n;
   endfunction

endpackage

@@ sv/fbfl_ctrl.sv @@
// Controller of the fixed block free list allocator: handshake and sequencing.
// Depends on fbfl_pkg.
module fbfl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  fbfl_pkg::fbfl_sts_type sts,
   output fbfl_pkg::fbfl_cmd_type cmd
);
   import fbfl_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LINK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // A new transaction is taken when idle and the result register is free or emptying.
   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && sts.link_needed) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign cmd.accept      = accept;
   assign cmd.follow_link = (state_ff == S_LINK);

endmodule

@@ sv/fbfl_dpath.sv @@
// Datapath of the fixed block free list allocator: link memory, list registers,
// pool configuration and result register. Depends on fbfl_pkg.
module fbfl_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  fbfl_pkg::fbfl_cmd_type        cmd,
   output fbfl_pkg::fbfl_sts_type        sts,
   input  logic                          req_command,
   input  logic [fbfl_pkg::IDX_W-1:0]    req_release_index,
   input  logic                          csr_write_enable,
   input  logic [fbfl_pkg::CNT_W-1:0]    csr_write_data,
   output logic [1:0]                    rsp_status,
   output logic [fbfl_pkg::IDX_W-1:0]    rsp_granted_index,
   output logic [fbfl_pkg::CNT_W-1:0]    rsp_free_count
);
   import fbfl_pkg::*;

   logic [CNT_W-1:0] link_mem [MAX_BLOCKS];

   logic [CNT_W-1:0] block_count_ff, block_count_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic             head_valid_ff, head_valid_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] init_ff, init_in;
   logic [CNT_W-1:0] rd_data_ff;
   logic             bypass_ff;
   logic [CNT_W-1:0] bypass_data_ff;
   logic [1:0]       status_ff, status_in;
   logic [IDX_W-1:0] granted_ff, granted_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [CNT_W-1:0] pool_n;
   logic [CNT_W-1:0] rel_ext;
   logic [CNT_W-1:0] free_dec;
   logic [CNT_W-1:0] init_inc;
   logic             is_alloc;
   logic             lazy_we;
   logic             rel_ok;
   logic             alloc_ok;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [CNT_W-1:0] mem_wdata;
   logic [CNT_W-1:0] link_value;

   assign pool_n   = pool_size(block_count_ff);
   assign rel_ext  = CNT_W'(req_release_index);
   assign free_dec = free_ff - CNT_W'(1);
   assign init_inc = init_ff + CNT_W'(1);
   assign is_alloc = (req_command == CMD_ALLOC);
   assign alloc_ok = (free_ff != '0);
   assign rel_ok   = (rel_ext < pool_n) && (free_ff < pool_n);
   assign lazy_we  = cmd.accept && is_alloc && (init_ff < pool_n);

   assign sts.link_needed = is_alloc && alloc_ok && (free_dec != '0);

   // One write port: either the lazy link of an allocate or the push of a release.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = init_ff[IDX_W-1:0];
      mem_wdata = init_inc;
      if (lazy_we) begin
         mem_we = 1'b1;
      end else if (cmd.accept && !is_alloc && rel_ok) begin
         mem_we    = 1'b1;
         mem_waddr = req_release_index;
         mem_wdata = head_valid_ff ? head_ff : pool_n;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= link_mem[head_ff[IDX_W-1:0]];
   end

   // The lazy write lands in the same cycle as the head read, so it is forwarded.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bypass_ff      <= lazy_we && (init_ff == head_ff);
         bypass_data_ff <= init_inc;
      end
   end

   always_comb begin
      if (head_ff >= CNT_W'(MAX_BLOCKS)) begin
         link_value = '0;
      end else if (bypass_ff) begin
         link_value = bypass_data_ff;
      end else begin
         link_value = rd_data_ff;
      end
   end

   always_comb begin
      block_count_in = block_count_ff;
      head_in        = head_ff;
      head_valid_in  = head_valid_ff;
      free_in        = free_ff;
      init_in        = init_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      count_in       = count_ff;
      if (csr_write_enable) begin
         block_count_in = csr_write_data;
         head_in        = '0;
         head_valid_in  = 1'b1;
         free_in        = pool_size(csr_write_data);
         init_in        = '0;
      end else if (cmd.follow_link) begin
         head_in = link_value;
      end else if (cmd.accept) begin
         granted_in = '0;
         if (is_alloc) begin
            if (lazy_we) begin
               init_in = init_inc;
            end
            if (alloc_ok) begin
               status_in  = ST_OK;
               granted_in = head_ff[IDX_W-1:0];
               free_in    = free_dec;
               count_in   = free_dec;
               if (free_dec == '0) begin
                  head_valid_in = 1'b0;
               end
            end else begin
               status_in = ST_EXHAUSTED;
               count_in  = free_ff;
            end
         end else begin
            if (rel_ok) begin
               status_in     = ST_OK;
               head_in       = rel_ext;
               head_valid_in = 1'b1;
               free_in       = free_ff + CNT_W'(1);
               count_in      = free_ff + CNT_W'(1);
            end else begin
               status_in = ST_INVALID;
               count_in  = free_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= CNT_W'(MAX_BLOCKS);
         head_ff        <= '0;
         head_valid_ff  <= 1'b1;
         free_ff        <= CNT_W'(MAX_BLOCKS);
         init_ff        <= '0;
      end else begin
         block_count_ff <= block_count_in;
         head_ff        <= head_in;
         head_valid_ff  <= head_valid_in;
         free_ff        <= free_in;
         init_ff        <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      granted_ff <= granted_in;
      count_ff   <= count_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_free_count    = count_ff;

endmodule

@@ sv/fixed_block_free_list_allocator_unit.sv @@
// Top level of the fixed block free list allocator.
// Depends on fbfl_pkg, fbfl_ctrl, fbfl_dpath and the assertion macro header.
//
// The block hands out and takes back indices of equal-sized blocks kept on a
// linked free list in an on-chip link memory of MAX_BLOCKS entries. Each
// request transaction (req_valid/req_stall) carries a command, allocate or
// release, and the index to release. Each request yields exactly one response
// transaction (rsp_valid/rsp_stall) with a status, the granted index and the
// number of free blocks after the operation. The response appears in the cycle
// after the request is taken. A release, an allocate that empties the pool and
// an allocate that finds the pool exhausted skip the state S_LINK; any other
// allocate needs it, since the next head is a registered read of the link
// memory. The block takes one request at a time. When the receiver stalls, the
// response holds in its output register and no new request is taken until it
// leaves. The csr_ port writes the pool size; a write restarts the pool with
// all blocks free and may happen only while no transaction is in flight.
// Synchronous reset sets the pool size to MAX_BLOCKS with all blocks free; the
// link memory needs no clearing, since links are written lazily as blocks are
// first handed out.
`include "fixed_block_free_list_allocator_unit_assert.svh"

module fixed_block_free_list_allocator_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_command,
   input  logic [fbfl_pkg::IDX_W-1:0] req_release_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [fbfl_pkg::IDX_W-1:0] rsp_granted_index,
   output logic [fbfl_pkg::CNT_W-1:0] rsp_free_count,
   input  logic                       csr_write_enable,
   input  logic [fbfl_pkg::CNT_W-1:0] csr_write_data
);
   import fbfl_pkg::*;

   fbfl_cmd_type cmd;
   fbfl_sts_type sts;

   // The controller owns the handshake and the link-follow cycle.
   fbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the list state, the link memory and the response payload.
   fbfl_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_command       (req_command),
      .req_release_index (req_release_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_free_count    (rsp_free_count)
   );

   // A held response must block new requests, since there is no skid stage.
   `FBFL_ASSERT_SAME(a_hold_blocks_req, clock, reset, rsp_valid && rsp_stall, req_stall, "request taken while response held")
   // Every taken request produces a response in the next cycle.
   `FBFL_ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_valid && !req_stall, rsp_valid, "response missing after request")
   // An exhausted allocate can only report an empty pool.
   `FBFL_ASSERT_SAME(a_exhausted_empty, clock, reset, rsp_valid && (rsp_status == ST_EXHAUSTED), rsp_free_count == '0, "exhausted with free blocks")
   // The free count never exceeds the store.
   `FBFL_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, rsp_free_count <= CNT_W'(MAX_BLOCKS), "free count out of range")

endmodule
